// ----- rtl/core/afct_pkg.sv -----
// ----------------------------------------------------------------------------
// afct_pkg
// Shared types, constants and helpers for the angle/force calibration table.
// ----------------------------------------------------------------------------
package afct_pkg;

    // grid size
    localparam int MAX_POINTS = 32;
    localparam int AW         = $clog2(MAX_POINTS);
    localparam int CW         = $clog2(MAX_POINTS + 1);

    // shared serial divider widths
    localparam int DIV_W = 42;
    localparam int DEN_W = 17;

    // configuration register indexes
    localparam int          CFG_AW          = 3;
    localparam logic [2:0]  REG_ANGLE_LOW   = 3'd0;
    localparam logic [2:0]  REG_ANGLE_HIGH  = 3'd1;
    localparam logic [2:0]  REG_ANGLE_STEP  = 3'd2;
    localparam logic [2:0]  REG_SETTLE_TIME = 3'd3;
    localparam logic [2:0]  REG_RECORD_TIME = 3'd4;

    // configuration reset values
    localparam logic signed [15:0] RST_ANGLE_LOW   = 16'sd0;
    localparam logic signed [15:0] RST_ANGLE_HIGH  = 16'sd15360;
    localparam logic [14:0]        RST_ANGLE_STEP  = 15'd1280;
    localparam logic [31:0]        RST_SETTLE_TIME = 32'd1000000;
    localparam logic [31:0]        RST_RECORD_TIME = 32'd2000000;

    // sample count saturation
    localparam logic [15:0] COUNT_SAT = 16'hFFFF;

    // item operation codes
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_QUERY  = 2'd1,
        OP_START  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [23:0] force_sample;
        logic signed [15:0] query_angle;
        logic [31:0]        time_now;
    } item_t;

    typedef struct packed {
        logic signed [15:0] angle_low;
        logic signed [15:0] angle_high;
        logic [14:0]        angle_step;
        logic [31:0]        settle_time;
        logic [31:0]        record_time;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] target_angle;
        logic signed [23:0] force_out;
        logic               recording;
        logic               finished;
        logic               running;
    } result_t;

    // saturate a wide signed value to 24 bits
    function automatic logic signed [23:0] sat24(input logic signed [43:0] v);
        logic signed [23:0] r;
        if (v > 44'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -44'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage

// ----- rtl/core/afct_front.sv -----
// ----------------------------------------------------------------------------
// afct_front
// Input side: decodes the mode of each item and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module afct_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           mode,
    input  logic signed [23:0]   force_sample,
    input  logic signed [15:0]   query_angle,
    input  logic [31:0]          time_now,
    output afct_pkg::item_t      item,
    output logic                 item_valid,
    input  logic                 item_take
);

    afct_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      cnt_reg;
    afct_pkg::op_t   op;
    logic            wr_en;
    logic            rd_en;

    // classify the mode field
    always_comb
    begin
        unique case (mode)
            2'd0:    op = afct_pkg::OP_SAMPLE;
            2'd1:    op = afct_pkg::OP_QUERY;
            2'd2:    op = afct_pkg::OP_START;
            default: op = afct_pkg::OP_NONE;
        endcase
    end

    assign full       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = mem_reg[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = item_take && item_valid;

    // queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= '{op: op, force_sample: force_sample,
                                     query_angle: query_angle, time_now: time_now};
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 2'd1;
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

// ----- rtl/core/afct_div.sv -----
// ----------------------------------------------------------------------------
// afct_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module afct_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [afct_pkg::DIV_W-1:0]   dividend,
    input  logic [afct_pkg::DEN_W-1:0]   divisor,
    output logic                         done,
    output logic [afct_pkg::DIV_W-1:0]   quotient
);

    localparam int NW = $clog2(afct_pkg::DIV_W + 1);

    logic [afct_pkg::DIV_W-1:0] quo_reg;
    logic [afct_pkg::DEN_W-1:0] rem_reg;
    logic [afct_pkg::DEN_W-1:0] dsor_reg;
    logic [NW-1:0]              cnt_reg;
    logic                       done_reg;
    logic [afct_pkg::DEN_W:0]   rem_sh;
    logic [afct_pkg::DEN_W:0]   trial;

    // one trial subtraction
    assign rem_sh = {rem_reg, quo_reg[afct_pkg::DIV_W-1]};
    assign trial  = rem_sh - {1'b0, dsor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                cnt_reg <= NW'(afct_pkg::DIV_W);
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == NW'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dsor_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[afct_pkg::DEN_W])
            begin
                rem_reg <= trial[afct_pkg::DEN_W-1:0];
                quo_reg <= {quo_reg[afct_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[afct_pkg::DEN_W-1:0];
                quo_reg <= {quo_reg[afct_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/afct_back.sv -----
// ----------------------------------------------------------------------------
// afct_back
// Execution side: grid layout, timed recording, interpolated lookup and the
// two-entry result queue.
// ----------------------------------------------------------------------------
module afct_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  afct_pkg::cfg_t       cfg,
    input  afct_pkg::item_t      item,
    input  logic                 item_valid,
    output logic                 item_take,
    output logic                 empty,
    input  logic                 pop,
    output afct_pkg::result_t    result
);

    localparam int AW = afct_pkg::AW;
    localparam int CW = afct_pkg::CW;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_EXEC  = 13'b0000000000010,
        ST_LAY   = 13'b0000000000100,
        ST_SCAN  = 13'b0000000001000,
        ST_CMP   = 13'b0000000010000,
        ST_RD0   = 13'b0000000100000,
        ST_RD1   = 13'b0000001000000,
        ST_MUL   = 13'b0000010000000,
        ST_DIVS  = 13'b0000100000000,
        ST_DIVW  = 13'b0001000000000,
        ST_STORE = 13'b0010000000000,
        ST_TGT   = 13'b0100000000000,
        ST_FIN   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // table storage
    logic signed [15:0] ang_mem [afct_pkg::MAX_POINTS];
    logic signed [23:0] frc_mem [afct_pkg::MAX_POINTS];
    logic signed [15:0] ang_rd_reg;
    logic signed [23:0] frc_rd_reg;
    logic [AW-1:0]      rd_addr;
    logic               ang_we;
    logic [AW-1:0]      ang_wa;
    logic signed [15:0] ang_wd;
    logic [afct_pkg::MAX_POINTS-1:0] fvalid_reg;

    // calibration state
    afct_pkg::item_t    cur_reg;
    logic [CW-1:0]      ptcnt_reg;
    logic [AW-1:0]      pidx_reg;
    logic               rec_reg;
    logic               run_reg;
    logic               done_reg;
    logic               laid_reg;
    logic [31:0]        phase_reg;
    logic signed [39:0] sum_reg;
    logic [15:0]        cnt_reg;
    logic signed [15:0] tgt_reg;
    logic signed [23:0] fout_reg;
    logic signed [23:0] avg_reg;

    // layout and lookup working registers
    logic [AW-1:0]      k_reg;
    logic [20:0]        acc_reg;
    logic [AW-1:0]      j_reg;
    logic [AW-1:0]      seg_reg;
    logic signed [15:0] a0_reg;
    logic signed [23:0] f0_reg;
    logic signed [41:0] prod_reg;
    logic [16:0]        den_reg;
    logic               neg_reg;

    // result queue
    afct_pkg::result_t  omem_reg [2];
    logic               owr_reg;
    logic               ord_reg;
    logic [1:0]         ocnt_reg;
    logic               opush;
    logic               opop;

    // divider hookup
    logic                        div_start;
    logic [afct_pkg::DIV_W-1:0]  div_dend;
    logic [afct_pkg::DEN_W-1:0]  div_dsor;
    logic                        div_done;
    logic [afct_pkg::DIV_W-1:0]  div_quo;
    logic signed [42:0]          div_sres;

    // helpers
    logic [31:0]        dt;
    logic signed [16:0] diff;
    logic [14:0]        step_eff;
    logic               lay_more;
    logic [AW-1:0]      seg_next;
    logic signed [23:0] frc_sel;
    logic signed [16:0] dq;
    logic signed [24:0] df;
    logic [39:0]        sum_mag;
    logic [41:0]        prod_mag;
    logic               last_pt;

    assign dt       = cur_reg.time_now - phase_reg;
    assign diff     = 17'(cfg.angle_high) - 17'(cfg.angle_low);
    assign step_eff = (cfg.angle_step == '0) ? 15'd1 : cfg.angle_step;
    assign lay_more = (k_reg != AW'(afct_pkg::MAX_POINTS - 1))
                      && ($signed({1'b0, acc_reg}) < 22'(diff));
    assign seg_next = seg_reg + 1'b1;
    assign dq       = 17'(cur_reg.query_angle) - 17'(a0_reg);
    assign sum_mag  = sum_reg[39] ? 40'(-sum_reg) : 40'(sum_reg);
    assign prod_mag = prod_reg[41] ? 42'(-prod_reg) : 42'(prod_reg);
    assign last_pt  = ({1'b0, pidx_reg} + 1'b1) >= ptcnt_reg;
    assign div_sres = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

    // force read with never-written entries as zero
    always_comb
    begin
        if (state_reg == ST_RD1)
            frc_sel = fvalid_reg[seg_reg] ? frc_rd_reg : 24'sd0;
        else
            frc_sel = fvalid_reg[seg_next] ? frc_rd_reg : 24'sd0;
    end
    assign df = 25'(frc_sel) - 25'(f0_reg);

    // read address selection
    always_comb
    begin
        case (state_reg)
            ST_SCAN:  rd_addr = j_reg;
            ST_RD1:   rd_addr = seg_next;
            ST_STORE: rd_addr = pidx_reg + 1'b1;
            default:  rd_addr = seg_reg;
        endcase
    end

    // grid angle writes during layout
    assign ang_we = (state_reg == ST_LAY);
    assign ang_wa = k_reg;
    assign ang_wd = lay_more ? (cfg.angle_low + $signed(acc_reg[15:0])) : cfg.angle_high;

    always_ff @(posedge clk)
    begin
        if (ang_we)
            ang_mem[ang_wa] <= ang_wd;
        ang_rd_reg <= ang_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_STORE)
            frc_mem[pidx_reg] <= avg_reg;
        frc_rd_reg <= frc_mem[rd_addr];
    end

    // divider operands
    assign div_start = (state_reg == ST_DIVS);
    always_comb
    begin
        if (cur_reg.op == afct_pkg::OP_QUERY)
        begin
            div_dend = prod_mag + 42'(den_reg[16:1]);
            div_dsor = den_reg;
        end
        else
        begin
            div_dend = 42'(sum_mag) + 42'(cnt_reg[15:1]);
            div_dsor = 17'(cnt_reg);
        end
    end

    afct_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dend),
        .divisor  (div_dsor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sequencer
    assign item_take = (state_reg == ST_IDLE) && item_valid && (ocnt_reg != 2'd2);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (item_take) state_next = ST_EXEC;
            ST_EXEC:
            begin
                case (cur_reg.op)
                    afct_pkg::OP_START: state_next = ST_LAY;
                    afct_pkg::OP_SAMPLE:
                    begin
                        if (run_reg && rec_reg && (dt > cfg.record_time))
                            state_next = (cnt_reg == '0) ? ST_STORE : ST_DIVS;
                        else
                            state_next = ST_FIN;
                    end
                    afct_pkg::OP_QUERY:
                    begin
                        if (!laid_reg)
                            state_next = ST_FIN;
                        else if (ptcnt_reg == CW'(1))
                            state_next = ST_RD0;
                        else
                            state_next = ST_SCAN;
                    end
                    default: state_next = ST_FIN;
                endcase
            end
            ST_LAY:   if (!lay_more) state_next = ST_FIN;
            ST_SCAN:  state_next = ST_CMP;
            ST_CMP:
            begin
                if ((cur_reg.query_angle <= ang_rd_reg)
                    || ({1'b0, j_reg} == ptcnt_reg - 1'b1))
                    state_next = ST_RD0;
                else
                    state_next = ST_SCAN;
            end
            ST_RD0:   state_next = ST_RD1;
            ST_RD1:   state_next = (ptcnt_reg == CW'(1)) ? ST_FIN : ST_MUL;
            ST_MUL:   state_next = ST_DIVS;
            ST_DIVS:  state_next = ST_DIVW;
            ST_DIVW:
            begin
                if (div_done)
                    state_next = (cur_reg.op == afct_pkg::OP_QUERY) ? ST_FIN : ST_STORE;
            end
            ST_STORE: state_next = last_pt ? ST_FIN : ST_TGT;
            ST_TGT:   state_next = ST_FIN;
            ST_FIN:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // calibration state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptcnt_reg  <= CW'(1);
            pidx_reg   <= '0;
            rec_reg    <= 1'b0;
            run_reg    <= 1'b0;
            done_reg   <= 1'b0;
            laid_reg   <= 1'b0;
            phase_reg  <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            tgt_reg    <= '0;
            fvalid_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_EXEC:
                begin
                    if (cur_reg.op == afct_pkg::OP_START)
                        fvalid_reg <= '0;
                    else if ((cur_reg.op == afct_pkg::OP_SAMPLE) && run_reg)
                    begin
                        if (!rec_reg)
                        begin
                            if (dt > cfg.settle_time)
                            begin
                                rec_reg   <= 1'b1;
                                phase_reg <= cur_reg.time_now;
                            end
                        end
                        else if (!(dt > cfg.record_time) && (cnt_reg != afct_pkg::COUNT_SAT))
                        begin
                            sum_reg <= sum_reg + 40'(cur_reg.force_sample);
                            cnt_reg <= cnt_reg + 16'd1;
                        end
                    end
                end
                ST_LAY:
                begin
                    if (!lay_more)
                    begin
                        ptcnt_reg <= CW'(k_reg) + 1'b1;
                        pidx_reg  <= '0;
                        rec_reg   <= 1'b0;
                        sum_reg   <= '0;
                        cnt_reg   <= '0;
                        run_reg   <= 1'b1;
                        done_reg  <= 1'b0;
                        laid_reg  <= 1'b1;
                        phase_reg <= cur_reg.time_now;
                        tgt_reg   <= (k_reg == '0) ? cfg.angle_high : cfg.angle_low;
                    end
                end
                ST_STORE:
                begin
                    fvalid_reg[pidx_reg] <= 1'b1;
                    if (last_pt)
                    begin
                        run_reg  <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                        pidx_reg <= pidx_reg + 1'b1;
                    phase_reg <= cur_reg.time_now;
                    rec_reg   <= 1'b0;
                    sum_reg   <= '0;
                    cnt_reg   <= '0;
                end
                ST_TGT: tgt_reg <= ang_rd_reg;
                default: ;
            endcase
        end
    end

    // working datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE: if (item_take) cur_reg <= item;
            ST_EXEC:
            begin
                fout_reg <= '0;
                avg_reg  <= '0;
                k_reg    <= '0;
                acc_reg  <= '0;
                j_reg    <= AW'(1);
                seg_reg  <= '0;
            end
            ST_LAY:
            begin
                k_reg   <= k_reg + 1'b1;
                acc_reg <= acc_reg + 21'(step_eff);
            end
            ST_CMP:
            begin
                seg_reg <= j_reg - 1'b1;
                j_reg   <= j_reg + 1'b1;
            end
            ST_RD1:
            begin
                a0_reg   <= ang_rd_reg;
                f0_reg   <= frc_sel;
                fout_reg <= frc_sel;
            end
            ST_MUL:
            begin
                prod_reg <= dq * df;
                den_reg  <= 17'(ang_rd_reg) - 17'(a0_reg);
            end
            ST_DIVS:
            begin
                neg_reg <= (cur_reg.op == afct_pkg::OP_QUERY) ? prod_reg[41] : sum_reg[39];
            end
            ST_DIVW:
            begin
                if (div_done)
                begin
                    if (cur_reg.op == afct_pkg::OP_QUERY)
                        fout_reg <= afct_pkg::sat24(44'(f0_reg) + 44'(div_sres));
                    else
                        avg_reg <= afct_pkg::sat24(44'(div_sres));
                end
            end
            default: ;
        endcase
    end

    // result queue
    assign opush = (state_reg == ST_FIN);
    assign opop  = pop && !empty;
    assign empty = (ocnt_reg == 2'd0);
    assign result = omem_reg[ord_reg];

    always_ff @(posedge clk)
    begin
        if (opush)
        begin
            omem_reg[owr_reg] <= '{target_angle: laid_reg ? tgt_reg : 16'sd0,
                                  force_out: fout_reg, recording: rec_reg,
                                  finished: done_reg, running: run_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_reg  <= 1'b0;
            ord_reg  <= 1'b0;
            ocnt_reg <= 2'd0;
        end
        else
        begin
            if (opush)
                owr_reg <= ~owr_reg;
            if (opop)
                ord_reg <= ~ord_reg;
            if (opush && !opop)
                ocnt_reg <= ocnt_reg + 2'd1;
            else if (opop && !opush)
                ocnt_reg <= ocnt_reg - 2'd1;
        end
    end

endmodule

// ----- rtl/core/angle_force_calibration_table.sv -----
// ----------------------------------------------------------------------------
// angle_force_calibration_table
// Angle-to-force calibration table with timed recording and linear lookup.
// ----------------------------------------------------------------------------
// Start: layout sweep that writes the grid points through the angle memory;
//   sample: decode only, or an average through the serial divider and a store;
//   query: segment scan, table reads, multiply, then the serial divider.
// Throughput: one item at a time in the execution unit; results queue two deep.
// Reset: all control state cleared; grid angles hold nothing until a start.
module angle_force_calibration_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  mode,
    input  logic signed [23:0]          force_sample,
    input  logic signed [15:0]          query_angle,
    input  logic [31:0]                 time_now,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [15:0]          target_angle,
    output logic signed [23:0]          force_out,
    output logic                        recording,
    output logic                        finished,
    output logic                        running,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [afct_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [31:0]                 cfg_wdata
);

    afct_pkg::cfg_t    cfg_reg;
    afct_pkg::item_t   item;
    logic              item_valid;
    logic              item_take;
    afct_pkg::result_t result;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_low   <= afct_pkg::RST_ANGLE_LOW;
            cfg_reg.angle_high  <= afct_pkg::RST_ANGLE_HIGH;
            cfg_reg.angle_step  <= afct_pkg::RST_ANGLE_STEP;
            cfg_reg.settle_time <= afct_pkg::RST_SETTLE_TIME;
            cfg_reg.record_time <= afct_pkg::RST_RECORD_TIME;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                afct_pkg::REG_ANGLE_LOW:   cfg_reg.angle_low   <= cfg_wdata[15:0];
                afct_pkg::REG_ANGLE_HIGH:  cfg_reg.angle_high  <= cfg_wdata[15:0];
                afct_pkg::REG_ANGLE_STEP:  cfg_reg.angle_step  <= cfg_wdata[14:0];
                afct_pkg::REG_SETTLE_TIME: cfg_reg.settle_time <= cfg_wdata;
                afct_pkg::REG_RECORD_TIME: cfg_reg.record_time <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input queue
    afct_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .force_sample (force_sample),
        .query_angle  (query_angle),
        .time_now     (time_now),
        .item         (item),
        .item_valid   (item_valid),
        .item_take    (item_take)
    );

    // execution unit
    afct_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

    assign target_angle = result.target_angle;
    assign force_out    = result.force_out;
    assign recording    = result.recording;
    assign finished     = result.finished;
    assign running      = result.running;

    // recording only happens inside a run
    a_rec_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(recording && !running))
        else $error("recording reported outside a run");

    // a run and its completion never show together
    a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(finished && running))
        else $error("finished and running both set");

    // a full input queue always offers an item to the execution unit
    a_full_valid: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> item_valid)
        else $error("input queue full without a waiting item");

endmodule
